FILE: design/rpw_pkg.sv
// shared types and constants for the route pair watch table
package rpw_pkg;

    localparam int CODE_W  = 32;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_APPEND,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_READ_RD,
        ST_READ_CAP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [CODE_W-1:0] origin;
        logic [CODE_W-1:0] dest;
    } entry_t;

    typedef struct packed {
        logic               accepted;
        logic               matched;
        logic               index_valid;
        logic [CODE_W-1:0]  read_origin;
        logic [CODE_W-1:0]  read_dest;
        logic [COUNT_W-1:0] entry_count;
    } res_t;

endpackage

FILE: design/route_pair_watch_table_top.sv
// route pair watch table: top level with output register and checks
//
// input channel s_*: one beat is one operation (add, remove, lookup, read) with
// origin code, destination code and index. output channel m_*: one result beat
// per operation, carrying the flags, the read entry and the entry count after
// the operation.
// pairs live in one synchronous ram of ENTRIES words; every operation is run
// by a sequencer that reads, compares and writes that ram one entry per step.
// each operation is dispatched, then scans, shifts or reads the table entry by
// entry if it needs to, and then hands its result over; a rejected or
// out-of-range operation goes straight from dispatch to the handover. one
// operation is in work at a time: a beat is taken only while the sequencer
// idles, which it returns to once its result is handed over.
// the next operation is taken while a finished result waits in the output
// register; if the receiver stalls longer, the sequencer holds its result and
// stops taking beats.
// reset empties the table (count zero); no clearing pass is needed.
module route_pair_watch_table_top
    import rpw_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [CODE_W-1:0]  s_origin_code,
    input  logic [CODE_W-1:0]  s_dest_code,
    input  logic [IDX_W-1:0]   s_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic               m_matched,
    output logic               m_index_valid,
    output logic [CODE_W-1:0]  m_read_origin,
    output logic [CODE_W-1:0]  m_read_dest,
    output logic [COUNT_W-1:0] m_entry_count
);

    logic res_valid;
    logic res_ready;
    res_t res;

    logic m_valid_reg, m_valid_next;
    res_t out_reg;

    rpw_core #(
        .ENTRIES(ENTRIES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_op     (s_op),
        .in_origin (s_origin_code),
        .in_dest   (s_dest_code),
        .in_index  (s_index),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = out_reg.accepted;
    assign m_matched     = out_reg.matched;
    assign m_index_valid = out_reg.index_valid;
    assign m_read_origin = out_reg.read_origin;
    assign m_read_dest   = out_reg.read_dest;
    assign m_entry_count = out_reg.entry_count;

    // one operation in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("beat taken while an operation is in work");

    // at most one result flag per beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_accepted, m_matched, m_index_valid}))
        else $error("more than one result flag set");

    // read fields are zero unless a read hit a valid index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_index_valid |-> m_read_origin == '0 && m_read_dest == '0)
        else $error("read fields nonzero without a valid read");

    // a handed-over result shows up on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_valid)
        else $error("result lost between sequencer and output register");

endmodule

FILE: design/rpw_ram.sv
// generic single-write, single-read ram with registered read data
module rpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/rpw_core.sv
// sequencer that scans, appends, shifts and reads entries in the pair memory
module rpw_core
    import rpw_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_op,
    input  logic [CODE_W-1:0] in_origin,
    input  logic [CODE_W-1:0] in_dest,
    input  logic [IDX_W-1:0]  in_index,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    state_t state_reg, state_next;

    op_t               op_reg, op_next;
    logic [CODE_W-1:0] org_reg, org_next;
    logic [CODE_W-1:0] dst_reg, dst_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              acc_reg, acc_next;
    logic              hit_reg, hit_next;
    logic              valid_reg, valid_next;
    logic [CODE_W-1:0] ro_reg, ro_next;
    logic [CODE_W-1:0] rd_reg, rd_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    logic          query_empty, table_full, count_zero;
    logic          idx_in, idx_last;
    logic [CW-1:0] ptr_inc, ptr_inc2;
    logic          scan_last, shift_last;
    logic          dup, hit;

    rpw_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign query_empty = (org_reg == '0) && (dst_reg == '0);
    assign table_full  = (count_reg == CW'(ENTRIES));
    assign count_zero  = (count_reg == '0);
    assign idx_in      = XW'(idx_reg) < XW'(count_reg);
    assign idx_last    = (XW'(idx_reg) + XW'(1)) == XW'(count_reg);
    assign ptr_inc     = CW'(ptr_reg + 1'b1);
    assign ptr_inc2    = CW'(ptr_reg + 2'd2);
    assign scan_last   = (ptr_inc == count_reg);
    assign shift_last  = (ptr_inc2 == count_reg);
    assign dup         = (ram_rdata.origin == org_reg) && (ram_rdata.dest == dst_reg);
    assign hit         = ((ram_rdata.origin != '0) || (ram_rdata.dest != '0))
                      && ((ram_rdata.origin == '0) || (ram_rdata.origin == org_reg))
                      && ((ram_rdata.dest == '0) || (ram_rdata.dest == dst_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (op_reg)
                    OP_ADD: begin
                        if (query_empty || table_full) begin
                            state_next = ST_RESP;
                        end else if (count_zero) begin
                            state_next = ST_APPEND;
                        end else begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                    OP_REMOVE: begin
                        if (!idx_in || idx_last) begin
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_SHIFT_RD;
                        end
                    end
                    OP_LOOKUP: begin
                        if (query_empty || count_zero) begin
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                    OP_READ: begin
                        state_next = idx_in ? ST_READ_RD : ST_RESP;
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_SCAN_RD: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (op_reg == OP_ADD) begin
                    if (dup) begin
                        state_next = ST_RESP;
                    end else if (scan_last) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end else begin
                    state_next = (hit || scan_last) ? ST_RESP : ST_SCAN_RD;
                end
            end
            ST_APPEND:   state_next = ST_RESP;
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = shift_last ? ST_RESP : ST_SHIFT_RD;
            ST_READ_RD:  state_next = ST_READ_CAP;
            ST_READ_CAP: state_next = ST_RESP;
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        op_next    = op_reg;
        org_next   = org_reg;
        dst_next   = dst_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        acc_next   = acc_reg;
        hit_next   = hit_reg;
        valid_next = valid_reg;
        ro_next    = ro_reg;
        rd_next    = rd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = op_t'(in_op);
                    org_next   = in_origin;
                    dst_next   = in_dest;
                    idx_next   = in_index;
                    acc_next   = 1'b0;
                    hit_next   = 1'b0;
                    valid_next = 1'b0;
                    ro_next    = '0;
                    rd_next    = '0;
                end
            end
            ST_DISPATCH: begin
                if (op_reg == OP_ADD || op_reg == OP_LOOKUP) begin
                    ptr_next = '0;
                end else begin
                    ptr_next = CW'(idx_reg);
                end
                // removing the last entry needs no shift
                if (op_reg == OP_REMOVE && idx_in && idx_last) begin
                    count_next = CW'(count_reg - 1'b1);
                    acc_next   = 1'b1;
                end
            end
            ST_SCAN_CMP: begin
                if (op_reg == OP_ADD && dup) begin
                    acc_next = 1'b1;
                end else if (op_reg == OP_LOOKUP && hit) begin
                    hit_next = 1'b1;
                end else if (!scan_last) begin
                    ptr_next = ptr_inc;
                end
            end
            ST_APPEND: begin
                count_next = CW'(count_reg + 1'b1);
                acc_next   = 1'b1;
            end
            ST_SHIFT_WR: begin
                if (shift_last) begin
                    count_next = CW'(count_reg - 1'b1);
                    acc_next   = 1'b1;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            ST_READ_CAP: begin
                valid_next = 1'b1;
                ro_next    = ram_rdata.origin;
                rd_next    = ram_rdata.dest;
            end
            default: ;
        endcase
    end

    // outputs and memory control
    always_comb begin
        in_ready  = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_RESP);
        ram_re    = (state_reg == ST_SCAN_RD) || (state_reg == ST_SHIFT_RD)
                 || (state_reg == ST_READ_RD);
        ram_raddr = (state_reg == ST_SHIFT_RD) ? ptr_inc[AW-1:0] : ptr_reg[AW-1:0];
        ram_we    = (state_reg == ST_APPEND) || (state_reg == ST_SHIFT_WR);
        if (state_reg == ST_APPEND) begin
            ram_waddr        = count_reg[AW-1:0];
            ram_wdata.origin = org_reg;
            ram_wdata.dest   = dst_reg;
        end else begin
            ram_waddr = ptr_reg[AW-1:0];
            ram_wdata = ram_rdata;
        end
    end

    always_comb begin
        res.accepted    = acc_reg;
        res.matched     = hit_reg;
        res.index_valid = valid_reg;
        res.read_origin = ro_reg;
        res.read_dest   = rd_reg;
        res.entry_count = COUNT_W'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        org_reg   <= org_next;
        dst_reg   <= dst_next;
        idx_reg   <= idx_next;
        ptr_reg   <= ptr_next;
        acc_reg   <= acc_next;
        hit_reg   <= hit_next;
        valid_reg <= valid_next;
        ro_reg    <= ro_next;
        rd_reg    <= rd_next;
    end

endmodule

FILE: dv/testbench.sv
// testbench for the route pair watch table: random and directed operations checked beat by beat
module testbench
    import rpw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 16;
    localparam int LIMIT   = 600000;

    typedef struct packed {
        logic              pause;
        op_t               op;
        logic [CODE_W-1:0] origin;
        logic [CODE_W-1:0] dest;
        logic [IDX_W-1:0]  idx;
    } route_op_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = OP_ADD;
    logic [CODE_W-1:0]  s_origin_code = '0;
    logic [CODE_W-1:0]  s_dest_code = '0;
    logic [IDX_W-1:0]   s_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_accepted;
    logic               m_matched;
    logic               m_index_valid;
    logic [CODE_W-1:0]  m_read_origin;
    logic [CODE_W-1:0]  m_read_dest;
    logic [COUNT_W-1:0] m_entry_count;

    route_op_t pending_ops[$];
    res_t      expected_results[$];
    route_op_t offer;
    logic      op_taken = 1'b0;
    int        ops_taken = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        send_gap = 0;
    int        sink_gap = 0;
    int        stall_left = 0;
    logic      stall_done = 1'b0;
    int        cycles = 0;

    logic [CODE_W-1:0] tbl_origin [ENTRIES];
    logic [CODE_W-1:0] tbl_dest [ENTRIES];
    int                tbl_fill = 0;

    route_pair_watch_table_top #(.ENTRIES(ENTRIES)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_origin_code (s_origin_code),
        .s_dest_code   (s_dest_code),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_matched     (m_matched),
        .m_index_valid (m_index_valid),
        .m_read_origin (m_read_origin),
        .m_read_dest   (m_read_dest),
        .m_entry_count (m_entry_count)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic res_t table_apply(route_op_t b);
        res_t r;
        logic dup;
        r = '0;
        dup = 1'b0;
        case (b.op)
            OP_ADD: begin
                if ((b.origin != 0 || b.dest != 0) && tbl_fill < ENTRIES) begin
                    for (int i = 0; i < tbl_fill; i++)
                        if (tbl_origin[i] == b.origin && tbl_dest[i] == b.dest)
                            dup = 1'b1;
                    if (!dup) begin
                        tbl_origin[tbl_fill] = b.origin;
                        tbl_dest[tbl_fill] = b.dest;
                        tbl_fill++;
                    end
                    r.accepted = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (b.idx < tbl_fill) begin
                    for (int i = b.idx; i + 1 < tbl_fill; i++) begin
                        tbl_origin[i] = tbl_origin[i + 1];
                        tbl_dest[i] = tbl_dest[i + 1];
                    end
                    tbl_fill--;
                    tbl_origin[tbl_fill] = '0;
                    tbl_dest[tbl_fill] = '0;
                    r.accepted = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (b.origin != 0 || b.dest != 0) begin
                    for (int i = 0; i < tbl_fill; i++)
                        if ((tbl_origin[i] != 0 || tbl_dest[i] != 0) &&
                            (tbl_origin[i] == 0 || tbl_origin[i] == b.origin) &&
                            (tbl_dest[i] == 0 || tbl_dest[i] == b.dest))
                            r.matched = 1'b1;
                end
            end
            default: begin
                if (b.idx < tbl_fill) begin
                    r.index_valid = 1'b1;
                    r.read_origin = tbl_origin[b.idx];
                    r.read_dest = tbl_dest[b.idx];
                end
            end
        endcase
        r.entry_count = COUNT_W'(tbl_fill);
        return r;
    endfunction

    function automatic void queue_op(op_t op, logic [CODE_W-1:0] origin,
                                     logic [CODE_W-1:0] dest, int idx, logic pause);
        route_op_t b;
        b.pause = pause;
        b.op = op;
        b.origin = origin;
        b.dest = dest;
        b.idx = IDX_W'(idx);
        pending_ops.push_back(b);
    endfunction

    // mostly letter codes, now and then an arbitrary word
    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] c;
        int len;
        c = '0;
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
            c[31 - 8 * k -: 8] = 8'h41 + 8'($urandom_range(0, 25));
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code(logic [CODE_W-1:0] pool [6]);
        if ($urandom_range(0, 5) == 0)
            return '0;
        return pool[$urandom_range(0, 5)];
    endfunction

    function automatic logic idling_allowed();
        return pending_ops.size() >= 150 && (ops_taken / 120) % 3 != 2;
    endfunction

    // driver
    always @(negedge aclk) begin
        logic valid_next;
        route_op_t nxt;
        valid_next = s_valid && !op_taken;
        op_taken = 1'b0;
        if (aresetn && !valid_next) begin
            if (send_gap != 0) begin
                send_gap--;
            end else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].pause && expected_results.size() != 0)) begin
                if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 5);
                end else begin
                    nxt = pending_ops.pop_front();
                    offer = nxt;
                    s_op <= nxt.op;
                    s_origin_code <= nxt.origin;
                    s_dest_code <= nxt.dest;
                    s_index <= nxt.idx;
                    valid_next = 1'b1;
                end
            end
        end
        s_valid <= valid_next;
    end

    always @(negedge aclk) begin
        logic rdy;
        if (sink_gap != 0) begin
            sink_gap--;
            rdy = 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 5);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        if (stall_left != 0)
            rdy = 1'b0;
        m_ready <= rdy;
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (!stall_done && results_seen >= 400) begin
            stall_left = 500;
            stall_done = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(table_apply(offer));
            op_taken = 1'b1;
            ops_taken++;
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_accepted, m_matched, m_index_valid, m_read_origin, m_read_dest,
                   m_entry_count};
            results_seen++;
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("result beat %0d with nothing expected: ", results_seen,
                             "acc=%0b hit=%0b vld=%0b ",
                             got.accepted, got.matched, got.index_valid,
                             "org=%h dst=%h cnt=%0d",
                             got.read_origin, got.read_dest, got.entry_count);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    if (mismatches < 10)
                        $display("result beat %0d: ", results_seen,
                                 "expected acc=%0b hit=%0b vld=%0b ",
                                 want.accepted, want.matched, want.index_valid,
                                 "org=%h dst=%h cnt=%0d, ",
                                 want.read_origin, want.read_dest, want.entry_count,
                                 "got acc=%0b hit=%0b vld=%0b ",
                                 got.accepted, got.matched, got.index_valid,
                                 "org=%h dst=%h cnt=%0d",
                                 got.read_origin, got.read_dest, got.entry_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [CODE_W-1:0] origin_pool [6];
        logic [CODE_W-1:0] dest_pool [6];
        int roll;
        int add_w;
        int rem_w;
        op_t op;

        for (int i = 0; i < ENTRIES; i++) begin
            tbl_origin[i] = '0;
            tbl_dest[i] = '0;
        end

        // empty table, empty pair, duplicates, wildcards, extremes, range limits
        queue_op(OP_READ, '0, '0, 0, 1'b0);
        queue_op(OP_REMOVE, '0, '0, 0, 1'b0);
        queue_op(OP_LOOKUP, '0, '0, 0, 1'b0);
        queue_op(OP_LOOKUP, "FRA", "JFK", 0, 1'b0);
        queue_op(OP_ADD, '0, '0, 0, 1'b0);
        queue_op(OP_ADD, "FRA", "JFK", 0, 1'b0);
        queue_op(OP_ADD, "FRA", "JFK", 0, 1'b0);
        queue_op(OP_ADD, "LHR", '0, 0, 1'b0);
        queue_op(OP_ADD, '0, "SFO", 0, 1'b0);
        queue_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        queue_op(OP_ADD, 32'h0041_4243, 32'h4100_0042, 0, 1'b0);
        queue_op(OP_LOOKUP, "LHR", "XYZ", 0, 1'b0);
        queue_op(OP_LOOKUP, "MUC", "SFO", 0, 1'b0);
        queue_op(OP_LOOKUP, "FRA", "JFK", 0, 1'b0);
        queue_op(OP_LOOKUP, "FRA", "BOS", 0, 1'b0);
        queue_op(OP_LOOKUP, 32'h0041_4243, 32'h4100_0042, 0, 1'b0);
        queue_op(OP_READ, '0, '0, 3, 1'b0);
        queue_op(OP_READ, '0, '0, 15, 1'b0);
        queue_op(OP_REMOVE, '0, '0, 1, 1'b0);
        queue_op(OP_READ, '0, '0, 1, 1'b0);
        queue_op(OP_REMOVE, '0, '0, 15, 1'b0);
        queue_op(OP_LOOKUP, "LHR", "XYZ", 0, 1'b0);

        // phases that fill, mix and drain the table
        for (int ph = 0; ph < 15; ph++) begin
            for (int k = 0; k < 6; k++) begin
                origin_pool[k] = random_code();
                dest_pool[k] = random_code();
            end
            add_w = (ph % 3 == 0) ? 70 : (ph % 3 == 1) ? 35 : 20;
            rem_w = (ph % 3 == 2) ? 45 : 15;
            for (int n = 0; n < 102; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < add_w)
                    op = OP_ADD;
                else if (roll < add_w + rem_w)
                    op = OP_REMOVE;
                else if (roll % 2 == 0)
                    op = OP_LOOKUP;
                else
                    op = OP_READ;
                queue_op(op, pick_code(origin_pool), pick_code(dest_pool),
                         $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 5),
                         (ph == 7 || ph == 12) && n == 0);
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (2 * ENTRIES + 8) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/rpw_pkg.sv
design/rpw_ram.sv
design/rpw_core.sv
design/route_pair_watch_table_top.sv
dv/testbench.sv
